// ===== rtl/lcdns_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the character LCD nibble bus sequencer.
// No dependencies.
package lcdns_pkg;

  localparam logic [1:0] MODE_BYTE   = 2'd0;
  localparam logic [1:0] MODE_CURSOR = 2'd1;
  localparam logic [1:0] MODE_INIT   = 2'd2;

  localparam logic [1:0] REG_PULSE      = 2'd0;
  localparam logic [1:0] REG_SETTLE     = 2'd1;
  localparam logic [1:0] REG_SLOW_EXTRA = 2'd2;
  localparam logic [1:0] REG_POWER_WAIT = 2'd3;

  localparam logic [7:0]  CMD_SET_DDRAM     = 8'h80;
  localparam logic [7:0]  CMD_CLEAR         = 8'h01;
  localparam logic [7:0]  CMD_HOME          = 8'h02;
  localparam logic [6:0]  ROW1_BASE         = 7'h40;
  localparam logic [12:0] FIRST_INIT_WAIT_US = 13'd5000;
  localparam logic [12:0] INIT_WAIT_US       = 13'd150;

  // init events: one power wait, then 12 nibbles of two events each
  localparam logic [4:0] INIT_LAST_IDX = 5'd24;
  localparam logic [4:0] BYTE_LAST_IDX = 5'd3;
  localparam logic [3:0] INIT_CLEAR_LO = 4'd9;

  typedef enum logic {
    JOB_BYTE = 1'b0,
    JOB_INIT = 1'b1
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] value;
    logic       rs;
    logic       slow;
  } job_t;

  typedef struct packed {
    logic [7:0]  pulse;
    logic [9:0]  settle;
    logic [12:0] slow_extra;
    logic [15:0] power_wait;
  } cfg_t;

  // nibble order of the init sequence: 3,3,3,2 then 0x28 0x0C 0x01 0x06
  function automatic logic [3:0] init_nibble(input logic [3:0] n);
    logic [3:0] r;
    case (n)
      4'd0:    r = 4'h3;
      4'd1:    r = 4'h3;
      4'd2:    r = 4'h3;
      4'd3:    r = 4'h2;
      4'd4:    r = 4'h2;
      4'd5:    r = 4'h8;
      4'd6:    r = 4'h0;
      4'd7:    r = 4'hC;
      4'd8:    r = 4'h0;
      4'd9:    r = 4'h1;
      4'd10:   r = 4'h0;
      4'd11:   r = 4'h6;
      default: r = 4'h0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/char_lcd_nibble_bus_sequencer.sv =====
`timescale 1ns / 1ps
// Top level of the 4-bit character LCD bus sequencer: config registers, front, queue, back.
// Depends on lcdns_pkg, lcdns_front, lcdns_queue, lcdns_back.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_ready    mode byte_value reg_select column row_sel
//   out      source     out_valid / out_ready  bus_nibble rs_level enable_level hold_us last
//   cfg      sink       cfg_we                 cfg_index cfg_data
//
// A byte or cursor request yields 4 words, one a cycle while out_ready is high; an init request yields 25.
// The sequencer loads a queued job when idle, or in the same cycle as the previous job's last word.
// Request acceptance only stalls when the job queue is full; mode 3 is taken and dropped.
// Output words stall in the output register while out_ready is low.
// Reset is synchronous; registers return to 1, 100, 2000, 50000 us.
module char_lcd_nibble_bus_sequencer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [7:0]  byte_value,
  input  logic        reg_select,
  input  logic [5:0]  column,
  input  logic        row_sel,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  bus_nibble,
  output logic        rs_level,
  output logic        enable_level,
  output logic [15:0] hold_us,
  output logic        last
);
  import lcdns_pkg::*;

  cfg_t cfg;
  logic q_full;
  logic q_push;
  job_t q_wr_job;
  logic q_pop;
  logic q_valid;
  job_t q_rd_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse      <= 8'd1;
      cfg.settle     <= 10'd100;
      cfg.slow_extra <= 13'd2000;
      cfg.power_wait <= 16'd50000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PULSE:      cfg.pulse      <= cfg_data[7:0];
        REG_SETTLE:     cfg.settle     <= cfg_data[9:0];
        REG_SLOW_EXTRA: cfg.slow_extra <= cfg_data[12:0];
        REG_POWER_WAIT: cfg.power_wait <= cfg_data;
        default: ;
      endcase
    end
  end

  lcdns_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .byte_value (byte_value),
    .reg_select (reg_select),
    .column     (column),
    .row_sel    (row_sel),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (q_wr_job)
  );

  lcdns_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_job   (q_wr_job),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_job   (q_rd_job)
  );

  lcdns_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_job        (q_rd_job),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .bus_nibble   (bus_nibble),
    .rs_level     (rs_level),
    .enable_level (enable_level),
    .hold_us      (hold_us),
    .last         (last)
  );

endmodule

// ===== rtl/lcdns_front.sv =====
`timescale 1ns / 1ps
// Request front end: classifies a request into a byte job or an init job.
// Depends on lcdns_pkg.
module lcdns_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        mode,
  input  logic [7:0]        byte_value,
  input  logic              reg_select,
  input  logic [5:0]        column,
  input  logic              row_sel,
  input  logic              q_full,
  output logic              q_push,
  output lcdns_pkg::job_t   q_job
);
  import lcdns_pkg::*;

  logic [6:0] addr;
  logic [7:0] value;
  logic       rs;

  assign addr = {1'b0, column} + (row_sel ? ROW1_BASE : 7'h00);

  always_comb begin
    value = byte_value;
    rs    = reg_select;
    if (mode == MODE_CURSOR) begin
      value = CMD_SET_DDRAM | {1'b0, addr};
      rs    = 1'b0;
    end
  end

  assign in_ready = !q_full;
  // unused mode code is taken and dropped
  assign q_push   = in_valid && in_ready &&
                    (mode == MODE_BYTE || mode == MODE_CURSOR || mode == MODE_INIT);

  always_comb begin
    q_job.kind  = (mode == MODE_INIT) ? JOB_INIT : JOB_BYTE;
    q_job.value = value;
    q_job.rs    = rs;
    q_job.slow  = (mode != MODE_INIT) && !rs && (value == CMD_CLEAR || value == CMD_HOME);
  end

endmodule

// ===== rtl/lcdns_queue.sv =====
`timescale 1ns / 1ps
// Small job queue between front end and event sequencer.
// Depends on lcdns_pkg.
module lcdns_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lcdns_pkg::job_t wr_job,
  output logic            full,
  input  logic            pop,
  output logic            rd_valid,
  output lcdns_pkg::job_t rd_job
);
  import lcdns_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_job   = mem[rd_ptr];

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_job;
    end
  end

endmodule

// ===== rtl/lcdns_back.sv =====
`timescale 1ns / 1ps
// Event sequencer: walks a job through its timed pin events into an output word register.
// Depends on lcdns_pkg.
module lcdns_back (
  input  logic              clk,
  input  logic              rst,
  input  lcdns_pkg::cfg_t   cfg,
  input  logic              q_valid,
  input  lcdns_pkg::job_t   q_job,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [3:0]        bus_nibble,
  output logic              rs_level,
  output logic              enable_level,
  output logic [15:0]       hold_us,
  output logic              last
);
  import lcdns_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t     state;
  job_t       job;
  logic [4:0] idx;

  logic        slot_free;
  logic        emit;
  logic        is_init;
  logic [4:0]  k;
  logic [3:0]  n;
  logic        e_high;
  logic [12:0] extra;
  logic [13:0] settle_sum;
  logic [3:0]  ev_nib;
  logic        ev_rs;
  logic        ev_en;
  logic [15:0] ev_hold;
  logic        ev_last;
  logic        load;

  assign is_init    = (job.kind == JOB_INIT);
  assign k          = is_init ? idx - 5'd1 : idx;
  assign n          = k[4:1];
  assign e_high     = !k[0];
  assign settle_sum = {4'b0, cfg.settle} + {1'b0, extra};

  always_comb begin
    extra = '0;
    if (is_init) begin
      if (n == 4'd0) begin
        extra = FIRST_INIT_WAIT_US;
      end else if (n == 4'd1 || n == 4'd2 || n == 4'd3) begin
        extra = INIT_WAIT_US;
      end else if (n == INIT_CLEAR_LO) begin
        extra = cfg.slow_extra;
      end
    end else if (n[0] && job.slow) begin
      extra = cfg.slow_extra;
    end
  end

  always_comb begin
    ev_rs   = is_init ? 1'b0 : job.rs;
    ev_en   = e_high;
    ev_hold = e_high ? {8'b0, cfg.pulse} : {2'b0, settle_sum};
    if (is_init) begin
      ev_nib  = init_nibble(n);
      ev_last = (idx == INIT_LAST_IDX);
      if (idx == '0) begin
        ev_nib  = 4'h0;
        ev_en   = 1'b0;
        ev_hold = cfg.power_wait;
      end
    end else begin
      ev_nib  = n[0] ? job.value[3:0] : job.value[7:4];
      ev_last = (idx == BYTE_LAST_IDX);
    end
  end

  assign slot_free = !out_valid || out_ready;
  assign emit      = (state == ST_RUN) && slot_free;
  assign load      = q_valid && (state == ST_IDLE || (emit && ev_last));
  assign q_pop     = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        state <= ST_RUN;
      end else if (emit && ev_last) begin
        state <= ST_IDLE;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      bus_nibble   <= ev_nib;
      rs_level     <= ev_rs;
      enable_level <= ev_en;
      hold_us      <= ev_hold;
      last         <= ev_last;
    end
    if (load) begin
      job <= q_job;
      idx <= '0;
    end else if (emit) begin
      idx <= idx + 5'd1;
    end
  end

endmodule

// ===== rtl/lcdns_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks on the LCD bus sequencer output stream, bound to the top level.
// Depends on char_lcd_nibble_bus_sequencer port list only.
module lcdns_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  bus_nibble,
  input logic        rs_level,
  input logic        enable_level,
  input logic [15:0] hold_us,
  input logic        last
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(bus_nibble) && $stable(hold_us)
      && $stable(enable_level) && $stable(last))
    else $error("output word changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_strobe_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && enable_level |-> !last)
    else $error("request ended on an enable-high word");

  a_strobe_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && enable_level |=> out_valid && !enable_level
      && bus_nibble == $past(bus_nibble) && rs_level == $past(rs_level))
    else $error("enable-high word not followed by matching enable-low word");

endmodule

bind char_lcd_nibble_bus_sequencer lcdns_checker u_lcdns_checker (.*);

// ===== verif/tb_char_lcd_nibble_bus_sequencer.sv =====
`timescale 1ns / 1ps
// Testbench for char_lcd_nibble_bus_sequencer: directed and random requests under random
// stalls, with each bus event word checked in order against a scoreboard prediction.
// Depends on lcdns_pkg and the sequencer RTL.
module tb_char_lcd_nibble_bus_sequencer;
  import lcdns_pkg::*;

  localparam logic [1:0] MODE_UNUSED    = 2'd3;
  localparam logic [7:0] CMD_FUNC_4BIT  = 8'h28;
  localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;
  localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
  localparam logic [3:0] NIB_WAKE       = 4'h3;
  localparam logic [3:0] NIB_4BIT       = 4'h2;
  localparam int HOLD_MAX        = 65535;
  localparam int DRAIN_CYCLES    = 40;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct {
    logic [3:0]  nibble;
    logic        rs;
    logic        en;
    logic [15:0] hold;
    logic        last;
  } bus_word_t;

  class lcd_word_board;
    cfg_t      cfg;
    bus_word_t pending[$];
    int        errors;

    function new();
      cfg.pulse      = 8'd1;
      cfg.settle     = 10'd100;
      cfg.slow_extra = 13'd2000;
      cfg.power_wait = 16'd50000;
      errors = 0;
    endfunction

    function void set_reg(input logic [1:0] idx, input logic [15:0] data);
      case (idx)
        REG_PULSE:      cfg.pulse      = data[7:0];
        REG_SETTLE:     cfg.settle     = data[9:0];
        REG_SLOW_EXTRA: cfg.slow_extra = data[12:0];
        REG_POWER_WAIT: cfg.power_wait = data;
        default: ;
      endcase
    endfunction

    function void push_word(input logic [3:0] nib, input logic rs, input logic en,
                            input int hold);
      bus_word_t w;
      w.nibble = nib;
      w.rs     = rs;
      w.en     = en;
      w.hold   = (hold > HOLD_MAX) ? 16'hFFFF : 16'(hold);
      w.last   = 1'b0;
      pending.push_back(w);
    endfunction

    function void put_nibble(input logic [3:0] nib, input logic rs, input int extra);
      push_word(nib, rs, 1'b1, int'(cfg.pulse));
      push_word(nib, rs, 1'b0, int'(cfg.settle) + extra);
    endfunction

    function void put_byte(input logic [7:0] v, input logic rs);
      int extra;
      extra = 0;
      if (!rs && (v == CMD_CLEAR || v == CMD_HOME)) extra = int'(cfg.slow_extra);
      put_nibble(v[7:4], rs, 0);
      put_nibble(v[3:0], rs, extra);
    endfunction

    function void note_request(input logic [1:0] m, input logic [7:0] bv, input logic rsel,
                               input logic [5:0] col, input logic row);
      int        first;
      logic [6:0] addr;
      bus_word_t w;
      first = pending.size();
      addr = {1'b0, col} + (row ? ROW1_BASE : 7'h00);
      case (m)
        MODE_BYTE:   put_byte(bv, rsel);
        MODE_CURSOR: put_byte(CMD_SET_DDRAM | {1'b0, addr}, 1'b0);
        MODE_INIT: begin
          push_word(4'h0, 1'b0, 1'b0, int'(cfg.power_wait));
          put_nibble(NIB_WAKE, 1'b0, int'(FIRST_INIT_WAIT_US));
          put_nibble(NIB_WAKE, 1'b0, int'(INIT_WAIT_US));
          put_nibble(NIB_WAKE, 1'b0, int'(INIT_WAIT_US));
          put_nibble(NIB_4BIT, 1'b0, int'(INIT_WAIT_US));
          put_byte(CMD_FUNC_4BIT, 1'b0);
          put_byte(CMD_DISPLAY_ON, 1'b0);
          put_byte(CMD_CLEAR, 1'b0);
          put_byte(CMD_ENTRY_MODE, 1'b0);
        end
        default: ;
      endcase
      if (pending.size() > first) begin
        w = pending.pop_back();
        w.last = 1'b1;
        pending.push_back(w);
      end
    endfunction

    function void check_word(input logic [3:0] nib, input logic rs, input logic en,
                             input logic [15:0] hold, input logic last);
      bus_word_t w;
      if (pending.size() == 0) begin
        $error("unexpected word: bus_nibble %0h hold_us %0d", nib, hold);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (w.nibble !== nib) begin
        $error("bus_nibble: expected %0h, got %0h", w.nibble, nib);
        errors++;
      end
      if (w.rs !== rs) begin
        $error("rs_level: expected %0b, got %0b", w.rs, rs);
        errors++;
      end
      if (w.en !== en) begin
        $error("enable_level: expected %0b, got %0b", w.en, en);
        errors++;
      end
      if (w.hold !== hold) begin
        $error("hold_us: expected %0d, got %0d", w.hold, hold);
        errors++;
      end
      if (w.last !== last) begin
        $error("last: expected %0b, got %0b", w.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_PULSE;
  logic [15:0] cfg_data = 16'h0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  mode = MODE_BYTE;
  logic [7:0]  byte_value = 8'h0;
  logic        reg_select = 1'b0;
  logic [5:0]  column = 6'h0;
  logic        row_sel = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  bus_nibble;
  logic        rs_level;
  logic        enable_level;
  logic [15:0] hold_us;
  logic        last;

  bit fast_send = 1'b0;
  bit fast_recv = 1'b0;
  bit hold_off_req = 1'b0;

  lcd_word_board board = new();

  char_lcd_nibble_bus_sequencer uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .byte_value(byte_value), .reg_select(reg_select),
    .column(column), .row_sel(row_sel),
    .out_valid(out_valid), .out_ready(out_ready),
    .bus_nibble(bus_nibble), .rs_level(rs_level), .enable_level(enable_level),
    .hold_us(hold_us), .last(last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    board.set_reg(idx, data);
  endtask

  // junk fills the bits above each register's width
  task automatic apply_settings(input logic [7:0] p, input logic [9:0] s,
                                input logic [12:0] x, input logic [15:0] w, input bit junk);
    logic [15:0] upper;
    upper = junk ? 16'($urandom) : 16'h0;
    write_reg(REG_PULSE, {upper[7:0], p});
    write_reg(REG_SETTLE, {upper[5:0], s});
    write_reg(REG_SLOW_EXTRA, {upper[2:0], x});
    write_reg(REG_POWER_WAIT, w);
  endtask

  task automatic send_request(input logic [1:0] m, input logic [7:0] b, input logic r,
                              input logic [5:0] c, input logic rw);
    int gap;
    gap = fast_send ? 0 : $urandom_range(0, 12);
    repeat (gap) @(negedge clk);
    in_valid = 1'b1;
    mode = m;
    byte_value = b;
    reg_select = r;
    column = c;
    row_sel = rw;
    do @(posedge clk); while (!in_ready);
    board.note_request(m, b, r, c, rw);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_random();
    int         pick;
    logic [1:0] m;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    b = 8'($urandom_range(0, 255));
    if (pick < 55) m = MODE_BYTE;
    else if (pick < 85) m = MODE_CURSOR;
    else if (pick < 92) m = MODE_INIT;
    else m = MODE_UNUSED;
    if (m == MODE_BYTE && $urandom_range(0, 3) == 0)
      b = $urandom_range(0, 1) ? CMD_CLEAR : CMD_HOME;
    send_request(m, b, 1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)),
                 1'($urandom_range(0, 1)));
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic run_random(input int n);
    repeat (n) send_random();
    drain();
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // reset settings: byte extremes, slow commands, cursor corners, init, unused mode
    send_request(MODE_BYTE, 8'h00, 1'b0, 6'd0, 1'b0);
    send_request(MODE_BYTE, 8'hFF, 1'b1, 6'd63, 1'b1);
    send_request(MODE_BYTE, CMD_CLEAR, 1'b0, 6'd0, 1'b0);
    send_request(MODE_BYTE, CMD_HOME, 1'b0, 6'd0, 1'b0);
    send_request(MODE_BYTE, CMD_CLEAR, 1'b1, 6'd0, 1'b0);
    send_request(MODE_BYTE, CMD_HOME, 1'b1, 6'd0, 1'b0);
    send_request(MODE_BYTE, 8'hA5, 1'b0, 6'd21, 1'b1);
    send_request(MODE_BYTE, 8'h5A, 1'b1, 6'd42, 1'b0);
    send_request(MODE_CURSOR, 8'h00, 1'b0, 6'd0, 1'b0);
    send_request(MODE_CURSOR, 8'hFF, 1'b1, 6'd39, 1'b1);
    send_request(MODE_CURSOR, 8'h00, 1'b0, 6'd63, 1'b1);
    send_request(MODE_CURSOR, 8'h00, 1'b0, 6'd63, 1'b0);
    send_request(MODE_CURSOR, 8'h00, 1'b0, 6'd0, 1'b1);
    send_request(MODE_INIT, 8'hFF, 1'b1, 6'd63, 1'b1);
    send_request(MODE_UNUSED, 8'hFF, 1'b1, 6'd63, 1'b1);
    send_request(MODE_BYTE, 8'h3C, 1'b1, 6'd0, 1'b0);
    drain();

    apply_settings(8'd255, 10'd1023, 13'd8191, 16'd65535, 1'b0);
    run_random(20);

    // back to back on both sides
    apply_settings(8'd1, 10'd1, 13'd0, 16'd0, 1'b0);
    fast_send = 1'b1;
    fast_recv = 1'b1;
    run_random(20);
    fast_recv = 1'b0;
    fast_send = 1'b0;

    apply_settings(8'd0, 10'd0, 13'd0, 16'd0, 1'b1);
    run_random(12);

    // receiver stalls long while requests keep coming
    apply_settings(8'($urandom_range(1, 255)), 10'($urandom_range(1, 1023)),
                   13'($urandom_range(0, 8191)), 16'($urandom_range(0, 65535)), 1'b1);
    fast_send = 1'b1;
    hold_off_req = 1'b1;
    run_random(12);
    fast_send = 1'b0;

    repeat (2) begin
      apply_settings(8'($urandom_range(1, 255)), 10'($urandom_range(1, 1023)),
                     13'($urandom_range(0, 8191)), 16'($urandom_range(0, 65535)), 1'b1);
      run_random(20);
    end

    apply_settings(8'd1, 10'd100, 13'd2000, 16'd50000, 1'b0);
    run_random(15);

    if (board.errors == 0)
      $display("tb_char_lcd_nibble_bus_sequencer OK");
    else
      $display("tb_char_lcd_nibble_bus_sequencer NOT OK");
    $finish;
  end

  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off_req) begin
        out_ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      stall = fast_recv ? 0 : $urandom_range(0, 12);
      out_ready = 1'b0;
      repeat (stall) @(negedge clk);
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      board.check_word(bus_nibble, rs_level, enable_level, hold_us, last);
      @(negedge clk);
    end
  end

  initial begin
    #2000000;
    $display("tb_char_lcd_nibble_bus_sequencer NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lcdns_pkg.sv
rtl/lcdns_front.sv
rtl/lcdns_queue.sv
rtl/lcdns_back.sv
rtl/char_lcd_nibble_bus_sequencer.sv
rtl/lcdns_checker.sv
verif/tb_char_lcd_nibble_bus_sequencer.sv
